// ===== hdl/wnsm_pkg.sv =====
// Shared types and constants of the weighted node sort and merge block.
// Used by the product stage, the sort chain cells, the merge walker and the top level.
package wnsm_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int NODE_BITS   = 24;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 31;

    // Configuration register indexes.
    localparam logic REG_GRAD_EN  = 1'b0;
    localparam logic REG_DROP_THR = 1'b1;

    // One stored contribution after the products are formed.
    typedef struct packed {
        logic                 valid;
        logic [NODE_BITS-1:0] node;
        logic [30:0]          shape;
        logic signed [31:0]   gx;
        logic signed [31:0]   gy;
    } entry_t;

    // Chain commands; insert and shift are never issued together.
    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctrl_t;

    // One outgoing merged node.
    typedef struct packed {
        logic [23:0]        node;
        logic signed [37:0] shape;
        logic signed [40:0] gx;
        logic signed [40:0] gy;
        logic               valid;
        logic               last;
    } result_t;

endpackage

// ===== hdl/weighted_node_sort_merge_top.sv =====
// Weighted node sort and merge: one input transaction per cycle while a set loads.
// After the tlast transaction two product stages feed a chain walk that pops one entry per
// cycle while the result register can take each pushed node; the next set is taken once the
// last result of the set has been loaded into the result register.
// Synchronous active-low reset empties the sort chain, clears the entry count and
// returns gradients_enabled and drop_threshold to 1.
module weighted_node_sort_merge_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_index,
    input  logic [30:0]   cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // s_tdata from bit 0: node_id[24], corner_shape[31], shape_weight[31],
    // grad_weight_x[32], grad_weight_y[32], two zero pad bits.
    input  logic [151:0]  s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // m_tdata from bit 0: out_node[24], shape_sum[38], grad_x_sum[41], grad_y_sum[41].
    output logic [143:0]  m_tdata,
    // m_tuser: entry_valid.
    output logic          m_tuser,
    output logic          m_tlast
);
    import wnsm_pkg::*;

    logic             grad_en_reg;
    logic [CFG_W-1:0] thr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic             s_acc;
    logic             store;
    entry_t           new_ent;
    logic             new_vld;
    logic             set_end;
    logic             merge_done;
    logic             merge_shift;
    chain_ctrl_t      ctrl;
    result_t          res;

    entry_t           cell_ent [MAX_ENTRIES+1];
    logic [MAX_ENTRIES:0] take_vec;

    assign s_tready = !busy_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign store    = cnt_reg < CNT_W'(MAX_ENTRIES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grad_en_reg <= 1'b1;
            thr_reg     <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_GRAD_EN:  grad_en_reg <= cfg_wr_data[0];
                REG_DROP_THR: thr_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Items past the store capacity are dropped; their tlast still closes the set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            if (merge_done) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b0;
            end else if (s_acc) begin
                if (store) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (s_tlast) begin
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    wnsm_prod u_prod (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_vld        (s_acc),
        .in_store      (store),
        .in_last       (s_tlast),
        .node_id       (s_tdata[23:0]),
        .corner_shape  (s_tdata[54:24]),
        .shape_weight  (s_tdata[85:55]),
        .grad_weight_x (s_tdata[117:86]),
        .grad_weight_y (s_tdata[149:118]),
        .ent           (new_ent),
        .ent_vld       (new_vld),
        .set_end       (set_end)
    );

    assign ctrl.insert = new_vld;
    assign ctrl.shift  = merge_shift;

    assign cell_ent[MAX_ENTRIES] = '0;
    assign take_vec[0]           = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            wnsm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .new_ent   (new_ent),
                .left_ent  (new_ent),
                .left_take (take_vec[g]),
                .right_ent (cell_ent[g+1]),
                .ent       (cell_ent[g]),
                .take      (take_vec[g+1])
            );
        end else begin : g_body
            wnsm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .new_ent   (new_ent),
                .left_ent  (cell_ent[g-1]),
                .left_take (take_vec[g]),
                .right_ent (cell_ent[g+1]),
                .ent       (cell_ent[g]),
                .take      (take_vec[g+1])
            );
        end
    end

    wnsm_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (set_end),
        .head     (cell_ent[0]),
        .thr      (thr_reg),
        .grad_en  (grad_en_reg),
        .m_tready (m_tready),
        .shift    (merge_shift),
        .done     (merge_done),
        .m_tvalid (m_tvalid),
        .m_res    (res)
    );

    assign m_tdata = {res.gy, res.gx, res.shape, res.node};
    assign m_tuser = res.valid;
    assign m_tlast = res.last;

    a_no_insert_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.insert && ctrl.shift))
        else $error("sort chain got insert and shift together");

    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |-> !cell_ent[MAX_ENTRIES-1].valid)
        else $error("insert into a full sort chain");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past capacity");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty-set marker without tlast");

endmodule

// ===== hdl/wnsm_prod.sv =====
// Two-stage product pipeline: registered multiplies, then rounding and saturation.
// Depends on wnsm_pkg for entry_t and NODE_BITS.
module wnsm_prod (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_vld,
    input  logic                 in_store,
    input  logic                 in_last,
    input  logic [23:0]          node_id,
    input  logic [30:0]          corner_shape,
    input  logic [30:0]          shape_weight,
    input  logic signed [31:0]   grad_weight_x,
    input  logic signed [31:0]   grad_weight_y,
    output wnsm_pkg::entry_t     ent,
    output logic                 ent_vld,
    output logic                 set_end
);
    import wnsm_pkg::*;

    logic                 a_vld_reg;
    logic                 a_store_reg;
    logic                 a_last_reg;
    logic [NODE_BITS-1:0] a_node_reg;
    logic [61:0]          a_sp_reg;
    logic signed [63:0]   a_gx_reg;
    logic signed [63:0]   a_gy_reg;

    logic                 b_vld_reg;
    logic                 b_store_reg;
    logic                 b_last_reg;
    entry_t               b_ent_reg;

    logic signed [31:0]   cs_s;

    // Round half up and clamp to 31 unsigned bits.
    function automatic logic [30:0] shape_round(input logic [61:0] p);
        logic [62:0] t;
        logic [32:0] q;
        t = {1'b0, p} + 63'd536870912;
        q = t[62:30];
        if (q[32:31] != 2'b00) begin
            return 31'h7fffffff;
        end
        return q[30:0];
    endfunction

    // Round half toward plus infinity with a floor shift, clamp to 32 signed bits.
    function automatic logic signed [31:0] grad_round(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd536870912) >>> 30;
        if (r > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (r < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    assign cs_s = {1'b0, corner_shape};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
        a_store_reg <= in_store;
        a_last_reg  <= in_last;
        a_node_reg  <= NODE_BITS'(node_id);
        a_sp_reg    <= corner_shape * shape_weight;
        a_gx_reg    <= grad_weight_x * cs_s;
        a_gy_reg    <= grad_weight_y * cs_s;

        b_store_reg     <= a_store_reg;
        b_last_reg      <= a_last_reg;
        b_ent_reg.valid <= 1'b1;
        b_ent_reg.node  <= a_node_reg;
        b_ent_reg.shape <= shape_round(a_sp_reg);
        b_ent_reg.gx    <= grad_round(a_gx_reg);
        b_ent_reg.gy    <= grad_round(a_gy_reg);
    end

    assign ent     = b_ent_reg;
    assign ent_vld = b_vld_reg && b_store_reg;
    assign set_end = b_vld_reg && b_last_reg;

endmodule

// ===== hdl/wnsm_cell.sv =====
// One cell of the insertion sort chain: holds one entry, kept in ascending node order.
// Depends on wnsm_pkg for entry_t and chain_ctrl_t.
module wnsm_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wnsm_pkg::chain_ctrl_t ctrl,
    input  wnsm_pkg::entry_t      new_ent,
    input  wnsm_pkg::entry_t      left_ent,
    input  logic                  left_take,
    input  wnsm_pkg::entry_t      right_ent,
    output wnsm_pkg::entry_t      ent,
    output logic                  take
);
    import wnsm_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    // A cell yields its place when it is empty or holds a strictly larger node,
    // so equal nodes keep their arrival order.
    assign take = !ent_reg.valid || (ent_reg.node > new_ent.node);

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.shift) begin
            ent_next = right_ent;
        end else if (ctrl.insert && take) begin
            ent_next = left_take ? left_ent : new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

// ===== hdl/wnsm_merge.sv =====
// Merge walker: pops the sorted chain head, sums equal nodes, applies the threshold
// and drives the result register. Depends on wnsm_pkg for entry_t and result_t.
module wnsm_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  wnsm_pkg::entry_t     head,
    input  logic [30:0]          thr,
    input  logic                 grad_en,
    input  logic                 m_tready,
    output logic                 shift,
    output logic                 done,
    output logic                 m_tvalid,
    output wnsm_pkg::result_t    m_res
);
    import wnsm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]           st_reg, st_next;
    logic                 acc_vld_reg, acc_vld_next;
    logic [NODE_BITS-1:0] acc_node_reg, acc_node_next;
    logic signed [37:0]   acc_shape_reg, acc_shape_next;
    logic signed [40:0]   acc_gx_reg, acc_gx_next;
    logic signed [40:0]   acc_gy_reg, acc_gy_next;
    logic                 pend_vld_reg, pend_vld_next;
    result_t              pend_reg, pend_next;
    logic                 out_vld_reg, out_vld_next;
    result_t              out_reg, out_next;

    logic                 same;
    logic                 survivor;
    logic                 out_free;
    logic                 out_load;
    result_t              acc_res;

    function automatic logic signed [37:0] add_shape(input logic signed [37:0] a,
                                                     input logic [30:0] b);
        logic signed [38:0] s;
        s = {a[37], a} + $signed({8'b0, b});
        if (s[38] != s[37]) begin
            return s[38] ? {1'b1, 37'b0} : {1'b0, {37{1'b1}}};
        end
        return s[37:0];
    endfunction

    function automatic logic signed [40:0] add_grad(input logic signed [40:0] a,
                                                    input logic signed [31:0] b);
        logic signed [41:0] s;
        s = {a[40], a} + {{10{b[31]}}, b};
        if (s[41] != s[40]) begin
            return s[41] ? {1'b1, 40'b0} : {1'b0, {40{1'b1}}};
        end
        return s[40:0];
    endfunction

    assign same     = head.valid && acc_vld_reg && (head.node == acc_node_reg);
    assign survivor = acc_vld_reg && (acc_shape_reg > $signed({7'b0, thr}));
    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        acc_res.node  = 24'(acc_node_reg);
        acc_res.shape = acc_shape_reg;
        acc_res.gx    = grad_en ? acc_gx_reg : '0;
        acc_res.gy    = grad_en ? acc_gy_reg : '0;
        acc_res.valid = 1'b1;
        acc_res.last  = 1'b0;
    end

    always_comb begin
        st_next        = st_reg;
        acc_vld_next   = acc_vld_reg;
        acc_node_next  = acc_node_reg;
        acc_shape_next = acc_shape_reg;
        acc_gx_next    = acc_gx_reg;
        acc_gy_next    = acc_gy_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        out_load       = 1'b0;
        out_next       = pend_reg;
        shift          = 1'b0;
        done           = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (start) begin
                    st_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // Closing a surviving node pushes the one before it out, so the
                // walk waits only when that push meets a full result register.
                if (!(survivor && pend_vld_reg && !same) || out_free) begin
                    if (same) begin
                        acc_shape_next = add_shape(acc_shape_reg, head.shape);
                        acc_gx_next    = add_grad(acc_gx_reg, head.gx);
                        acc_gy_next    = add_grad(acc_gy_reg, head.gy);
                        shift          = 1'b1;
                    end else begin
                        if (survivor) begin
                            pend_next     = acc_res;
                            pend_vld_next = 1'b1;
                            if (pend_vld_reg) begin
                                out_load = 1'b1;
                            end
                        end
                        if (head.valid) begin
                            acc_vld_next   = 1'b1;
                            acc_node_next  = head.node;
                            acc_shape_next = {7'b0, head.shape};
                            acc_gx_next    = {{9{head.gx[31]}}, head.gx};
                            acc_gy_next    = {{9{head.gy[31]}}, head.gy};
                            shift          = 1'b1;
                        end else begin
                            acc_vld_next = 1'b0;
                            st_next      = ST_FINAL;
                        end
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_vld_reg) begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end else begin
                        out_next      = '0;
                        out_next.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    st_next       = ST_IDLE;
                    done          = 1'b1;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
        out_vld_next = out_load || (out_vld_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            acc_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            st_reg       <= st_next;
            acc_vld_reg  <= acc_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        acc_node_reg  <= acc_node_next;
        acc_shape_reg <= acc_shape_next;
        acc_gx_reg    <= acc_gx_next;
        acc_gy_reg    <= acc_gy_next;
        pend_reg      <= pend_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_res    = out_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for weighted_node_sort_merge_top: sends contribution sets on the
// input stream, predicts the sorted and merged nodes in a scoreboard class and checks them.
// Depends on wnsm_pkg and the top level RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wnsm_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 48;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 63;
    localparam longint SHAPE_HI     = (longint'(1) << 37) - 1;
    localparam longint SHAPE_LO     = -(longint'(1) << 37);
    localparam longint GSUM_HI      = (longint'(1) << 40) - 1;
    localparam longint GSUM_LO      = -(longint'(1) << 40);
    localparam longint GPROD_HI     = (longint'(1) << 31) - 1;
    localparam longint GPROD_LO     = -(longint'(1) << 31);

    typedef struct packed {
        logic [23:0]        node;
        logic [30:0]        corner_shape;
        logic [30:0]        shape_weight;
        logic signed [31:0] grad_wx;
        logic signed [31:0] grad_wy;
        logic               last;
    } contrib_t;

    typedef struct packed {
        logic [23:0]        node;
        logic [30:0]        shape;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } product_t;

    class node_merge_board;
        logic       grad_en;
        logic [30:0] threshold;
        product_t   held[$];
        result_t    merged_nodes[$];
        int         errors;

        function new();
            grad_en   = 1'b1;
            threshold = 31'd1;
            errors    = 0;
        endfunction

        function void set_register(logic idx, logic [30:0] value);
            if (idx == REG_GRAD_EN) begin
                grad_en = value[0];
            end else begin
                threshold = value;
            end
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function logic [30:0] shape_product(logic [30:0] cs, logic [30:0] sw);
            logic [63:0] p;
            p = (64'(cs) * 64'(sw) + (64'd1 << 29)) >> 30;
            return (p > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : p[30:0];
        endfunction

        // Rounds half toward plus infinity: add one half, then floor by arithmetic shift.
        function logic signed [31:0] grad_product(logic signed [31:0] w, logic [30:0] cs);
            longint p;
            p = longint'(w) * longint'(cs) + (longint'(1) << 29);
            p = clamp(p >>> 30, GPROD_LO, GPROD_HI);
            return p[31:0];
        endfunction

        function void note_contribution(contrib_t c);
            product_t e;
            // A full store drops the item, but its last mark still closes the set.
            if (held.size() < MAX_ENTRIES) begin
                e.node  = c.node;
                e.shape = shape_product(c.corner_shape, c.shape_weight);
                e.gx    = grad_product(c.grad_wx, c.corner_shape);
                e.gy    = grad_product(c.grad_wy, c.corner_shape);
                held.push_back(e);
            end
            if (c.last) begin
                merge_set();
                held.delete();
            end
        endfunction

        function void merge_set();
            product_t sorted[$];
            result_t  r;
            longint   ss;
            longint   sx;
            longint   sy;
            int       i;
            int       j;
            int       first_new;
            foreach (held[k]) begin
                j = sorted.size();
                while (j > 0 && sorted[j-1].node > held[k].node) j--;
                sorted.insert(j, held[k]);
            end
            first_new = merged_nodes.size();
            i = 0;
            while (i < sorted.size()) begin
                ss = 0;
                sx = 0;
                sy = 0;
                j  = i;
                while (j < sorted.size() && sorted[j].node == sorted[i].node) begin
                    ss = clamp(ss + longint'(sorted[j].shape), SHAPE_LO, SHAPE_HI);
                    sx = clamp(sx + longint'(sorted[j].gx), GSUM_LO, GSUM_HI);
                    sy = clamp(sy + longint'(sorted[j].gy), GSUM_LO, GSUM_HI);
                    j++;
                end
                if (ss > longint'(threshold)) begin
                    if (!grad_en) begin
                        sx = 0;
                        sy = 0;
                    end
                    r.node  = sorted[i].node;
                    r.shape = ss[37:0];
                    r.gx    = sx[40:0];
                    r.gy    = sy[40:0];
                    r.valid = 1'b1;
                    r.last  = 1'b0;
                    merged_nodes.push_back(r);
                end
                i = j;
            end
            // Nothing survived: a single invalid marker closes the set.
            if (merged_nodes.size() == first_new) begin
                r      = '0;
                r.last = 1'b1;
            end else begin
                r      = merged_nodes.pop_back();
                r.last = 1'b1;
            end
            merged_nodes.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [23:0] node, logic [40:0] got_v,
                           logic [40:0] want_v);
            if (got_v !== want_v) begin
                report($sformatf("node %0h %s: got %0h, expected %0h",
                                 node, name, got_v, want_v));
            end
        endtask

        task check_result(result_t got);
            result_t want;
            if (merged_nodes.size() == 0) begin
                report($sformatf("result for node %0h arrived with nothing expected",
                                 got.node));
                return;
            end
            want = merged_nodes.pop_front();
            compare_field("out_node", want.node, 41'(got.node), 41'(want.node));
            compare_field("shape_sum", want.node, 41'(got.shape), 41'(want.shape));
            compare_field("grad_x_sum", want.node, got.gx, want.gx);
            compare_field("grad_y_sum", want.node, got.gy, want.gy);
            compare_field("entry_valid", want.node, 41'(got.valid), 41'(want.valid));
            compare_field("last_result", want.node, 41'(got.last), 41'(want.last));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_wr_index;
    logic [30:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    node_merge_board board = new();
    int unsigned     cycle_count = 0;
    logic            send_calm = 1'b0;

    weighted_node_sort_merge_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic contrib_t make_contrib(logic [23:0] node, logic [30:0] cs,
                                              logic [30:0] sw, logic [31:0] gx,
                                              logic [31:0] gy, logic last);
        contrib_t c;
        c.node         = node;
        c.corner_shape = cs;
        c.shape_weight = sw;
        c.grad_wx      = gx;
        c.grad_wy      = gy;
        c.last         = last;
        return c;
    endfunction

    function automatic logic [30:0] pick_fraction(logic quarter_bias);
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'h4000_0000;
            2:       return 31'h7FFF_FFFF;
            3, 4, 5: return quarter_bias ? 31'h1000_0000
                                         : 31'($urandom_range(0, 32'h4000_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_grad();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3: begin
                v = 32'($urandom_range(0, 32'h0004_0000));
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic idx, logic [30:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_register(idx, value);
        @(posedge aclk);
    endtask

    // Called in the same time step as the previous acceptance, so tvalid either stays
    // high for a back-to-back transaction or drops for the gap.
    task automatic send_item(contrib_t c);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c.grad_wy, c.grad_wx, c.shape_weight, c.corner_shape, c.node};
        s_tlast  <= c.last;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        board.note_contribution(c);
    endtask

    task automatic send_random_set(output int count);
        int          n;
        int          node_style;
        logic [23:0] base;
        contrib_t    c;
        case ($urandom_range(0, 19))
            0:       n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 8);
            1, 2:    n = $urandom_range(11, MAX_ENTRIES);
            default: n = $urandom_range(1, 10);
        endcase
        node_style = $urandom_range(0, 3);
        base       = 24'($urandom_range(0, 24'hFF_FFF0));
        send_calm  = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            // Mostly a narrow window of node numbers so that merging happens often.
            case (node_style)
                0, 1:    c.node = base + 24'($urandom_range(0, 7));
                2:       c.node = 24'($urandom);
                default: begin
                    case ($urandom_range(0, 2))
                        0:       c.node = 24'h00_0000;
                        1:       c.node = 24'hFF_FFFF;
                        default: c.node = base;
                    endcase
                end
            endcase
            c.corner_shape = pick_fraction(1'b0);
            c.shape_weight = pick_fraction(1'b1);
            c.grad_wx      = pick_grad();
            c.grad_wy      = pick_grad();
            c.last         = (k == n - 1);
            send_item(c);
        end
        count = n;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.merged_nodes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_sink
        result_t got;
        int      stall;
        int      calm_left;
        m_tready <= 1'b0;
        calm_left = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 30);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            got.node  = m_tdata[23:0];
            got.shape = m_tdata[61:24];
            got.gx    = m_tdata[102:62];
            got.gy    = m_tdata[143:103];
            got.valid = m_tuser;
            got.last  = m_tlast;
            board.check_result(got);
        end
    end

    initial begin : stimulus
        int sent;
        int phase_items;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= REG_GRAD_EN;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full-scale values and saturating gradient weights.
        send_item(make_contrib(24'h0, 31'h4000_0000, 31'h4000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        // Saturating products, repeated nodes out of order, rounding at one half,
        // and a zero shape sum that falls under the threshold.
        send_item(make_contrib(24'hFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_item(make_contrib(24'h5, 31'h2000_0000, 31'd1, 32'h1, 32'hFFFF_FFFF, 1'b0));
        send_item(make_contrib(24'hFF_FFFF, 31'h4000_0000, 31'h1000_0000,
                               32'h0001_0000, 32'hFFFF_0000, 1'b0));
        send_item(make_contrib(24'h3, 31'd0, 31'h4000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_item(make_contrib(24'h5, 31'h2000_0000, 31'd1, 32'hFFFF_FFFF, 32'h1, 1'b1));
        drain();

        // A sum equal to the threshold is dropped, one above it is kept.
        write_reg(REG_DROP_THR, 31'd12345);
        send_item(make_contrib(24'hA, 31'h4000_0000, 31'd12345, pick_grad(), pick_grad(),
                               1'b0));
        send_item(make_contrib(24'hB, 31'h4000_0000, 31'd12346, pick_grad(), pick_grad(),
                               1'b1));
        drain();

        // Gradients off at the top threshold, then a set with no survivor.
        write_reg(REG_GRAD_EN, 31'd0);
        write_reg(REG_DROP_THR, 31'h4000_0000);
        send_item(make_contrib(24'h7, 31'h4000_0000, 31'h4000_0000, pick_grad(), pick_grad(),
                               1'b0));
        send_item(make_contrib(24'h9, 31'h4000_0000, 31'h3FFF_FFFF, pick_grad(), pick_grad(),
                               1'b0));
        send_item(make_contrib(24'h7, 31'h4000_0000, 31'd1, pick_grad(), pick_grad(), 1'b1));
        send_item(make_contrib(24'h8, 31'h4000_0000, 31'h4000_0000, pick_grad(), pick_grad(),
                               1'b1));
        drain();

        // Zero threshold: a zero sum is still dropped, the smallest nonzero sum is kept.
        write_reg(REG_GRAD_EN, 31'd1);
        write_reg(REG_DROP_THR, 31'd0);
        send_item(make_contrib(24'h4, 31'd0, 31'h7FFF_FFFF, pick_grad(), pick_grad(), 1'b1));
        send_item(make_contrib(24'h1, 31'd1, 31'h4000_0000, pick_grad(), pick_grad(), 1'b1));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_GRAD_EN, 31'd1);
                    write_reg(REG_DROP_THR, 31'd1);
                end
                1: begin
                    write_reg(REG_GRAD_EN, 31'd0);
                    write_reg(REG_DROP_THR, 31'd0);
                end
                2: begin
                    write_reg(REG_GRAD_EN, 31'd1);
                    write_reg(REG_DROP_THR, 31'h4000_0000);
                end
                3: begin
                    write_reg(REG_GRAD_EN, 31'd1);
                    write_reg(REG_DROP_THR, 31'($urandom_range(0, 32'h1000_0000)));
                end
                4: begin
                    write_reg(REG_GRAD_EN, 31'd0);
                    write_reg(REG_DROP_THR, 31'($urandom_range(0, 32'h4000_0000)));
                end
                5: begin
                    write_reg(REG_GRAD_EN, 31'd1);
                    write_reg(REG_DROP_THR, 31'd0);
                end
                6: begin
                    write_reg(REG_GRAD_EN, 31'd1);
                    write_reg(REG_DROP_THR, 31'h1000_0000);
                end
                default: begin
                    write_reg(REG_GRAD_EN, 31'd0);
                    write_reg(REG_DROP_THR, 31'd1);
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_set(sent);
                phase_items += sent;
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
